// ===== rtl/xor_linear_basis_defines.svh =====
// Assertion helpers used by the checker file.
`ifndef XOR_LINEAR_BASIS_DEFINES_SVH
`define XOR_LINEAR_BASIS_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define XLB_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("xlb assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define XLB_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("xlb assertion failed");

`endif

// ===== rtl/xlb_pkg.sv =====
`default_nettype none
package xlb_pkg;

  // Word geometry.
  localparam int TOP_BIT = 60;
  localparam int W       = TOP_BIT + 1;
  localparam int KW      = 62;
  localparam int SW      = 6;

  // Request codes.
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_QUERY  = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  // Input beat.
  typedef struct packed {
    logic [1:0]    req_type;
    logic [W-1:0]  value;
    logic [KW-1:0] kth_index;
  } xlb_in_t;

  // Result beat.
  typedef struct packed {
    logic          inserted;
    logic          representable;
    logic [W-1:0]  max_xor;
    logic [W-1:0]  min_xor;
    logic [W-1:0]  smallest_row;
    logic          smallest_valid;
    logic [W-1:0]  kth_value;
    logic          kth_valid;
    logic [W-1:0]  rank_of_value;
    logic [SW-1:0] basis_size;
    logic          zero_reachable;
  } xlb_out_t;

  // Token handed from one row cell to the next one down.
  typedef struct packed {
    logic          vld;
    logic          found;
    logic [W-1:0]  word;
    logic [W-1:0]  mx;
    logic [W-1:0]  mn;
    logic [W-1:0]  sm;
    logic          smv;
    logic [KW-1:0] kk;
    logic [W-1:0]  acc;
    logic [W-1:0]  rank;
  } xlb_carry_t;

  // Broadcast update to all row cells.
  typedef struct packed {
    logic         clr;
    logic         commit;
    logic [W-1:0] word;
    logic [W-1:0] pv;
  } xlb_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/xlb_cell.sv =====
`default_nettype none
module xlb_cell import xlb_pkg::*; #(
  parameter int IDX = 0
) (
  input  wire        clk,
  input  wire        rst_n,
  input  xlb_carry_t tok_i,
  input  xlb_cmd_t   cmd,
  output xlb_carry_t tok_o,
  output logic       claim_o
);

  logic [W-1:0] row_r, row_nxt;
  logic         pre_r, pre_nxt;
  logic         claim_r, claim_nxt;
  xlb_carry_t   tok_r, tok_nxt;
  logic         nz;
  logic         b;

  // Work on the passing token with this row.
  always_comb begin
    nz      = |row_r;
    b       = tok_i.word[IDX];
    tok_nxt = tok_i;
    tok_nxt.found = tok_i.found | (b & ~nz);
    if (nz) begin
      if (b) begin
        tok_nxt.word = tok_i.word ^ row_r;
      end
      if (!tok_i.mx[IDX]) begin
        tok_nxt.mx = tok_i.mx ^ row_r;
      end
      if (tok_i.mn[IDX]) begin
        tok_nxt.mn = tok_i.mn ^ row_r;
      end
      tok_nxt.sm  = row_r;
      tok_nxt.smv = 1'b1;
      if (tok_i.kk[KW-1]) begin
        tok_nxt.acc = tok_i.acc ^ row_r;
      end
      tok_nxt.kk   = {tok_i.kk[KW-2:0], 1'b0};
      tok_nxt.rank = {tok_i.rank[W-2:0], b};
    end
  end

  // Remember whether this row sits above the new pivot, or is the new pivot.
  always_comb begin
    pre_nxt   = pre_r;
    claim_nxt = claim_r;
    if (tok_i.vld) begin
      pre_nxt   = ~tok_i.found;
      claim_nxt = ~tok_i.found & b & ~nz;
    end
  end

  // Row update on clear or on a committed insert.
  always_comb begin
    priority if (cmd.clr) begin
      row_nxt = '0;
    end else if (cmd.commit && claim_r) begin
      row_nxt = cmd.word;
    end else if (cmd.commit && pre_r && (|(row_r & cmd.pv))) begin
      row_nxt = row_r ^ cmd.word;
    end else begin
      row_nxt = row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r   <= '0;
      pre_r   <= 1'b0;
      claim_r <= 1'b0;
      tok_r   <= '0;
    end else begin
      row_r   <= row_nxt;
      pre_r   <= pre_nxt;
      claim_r <= claim_nxt;
      tok_r   <= tok_nxt;
    end
  end

  assign tok_o   = tok_r;
  assign claim_o = claim_r;

endmodule
`default_nettype wire

// ===== rtl/xor_linear_basis.sv =====
// Insert and query beats walk a token from the launch register down the
// 61-cell row chain, one cell per cycle, and give their result from the output
// register; the input stays stalled meanwhile. Clear and unknown requests give
// theirs in the next cycle; clear beats may follow every cycle while the output
// is not stalled. Reset: synchronous active-low rst_n empties the basis, drops
// the zero flag and the output beat; no clearing pass is needed.
`default_nettype none
module xor_linear_basis import xlb_pkg::*; (
  input  wire      clk,
  input  wire      rst_n,
  input  wire      in_valid,
  output logic     in_stall,
  input  xlb_in_t  in_data,
  output logic     out_valid,
  input  wire      out_stall,
  output xlb_out_t out_data
);

  logic          busy_r, busy_nxt;
  logic [1:0]    req_r, req_nxt;
  logic          zf_r, zf_nxt;
  logic [SW-1:0] size_r, size_nxt;
  logic          kok_r, kok_nxt;
  logic          ov_r, ov_nxt;
  xlb_out_t      out_r, out_nxt;
  xlb_carry_t    launch_r, launch_nxt;
  xlb_carry_t    tok [0:W];
  logic [W-1:0]  claim;
  xlb_cmd_t      cmd;
  logic          accept;
  logic [KW-1:0] kadj;
  logic [6:0]    shamt;
  xlb_carry_t    tail;
  logic          ins;

  assign in_stall  = busy_r | (ov_r & out_stall);
  assign accept    = in_valid & ~in_stall;
  assign out_valid = ov_r;
  assign out_data  = out_r;

  // Chain of row cells, top row first.
  assign tok[W] = launch_r;
  for (genvar i = 0; i < W; i++) begin : g_cell
    xlb_cell #(.IDX(i)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .tok_i   (tok[i+1]),
      .cmd     (cmd),
      .tok_o   (tok[i]),
      .claim_o (claim[i])
    );
  end
  assign tail = tok[0];
  assign ins  = |tail.word;

  // Rank k prepared so that its bit for the top nonzero row leads.
  always_comb begin
    kadj  = zf_r ? (in_data.kth_index - KW'(1)) : in_data.kth_index;
    shamt = 7'(KW) - 7'(size_r);
  end

  // Control and result sequencing.
  always_comb begin
    busy_nxt   = busy_r;
    req_nxt    = req_r;
    zf_nxt     = zf_r;
    size_nxt   = size_r;
    kok_nxt    = kok_r;
    ov_nxt     = ov_r & out_stall;
    out_nxt    = out_r;
    launch_nxt = '0;
    cmd        = '0;
    cmd.word   = tail.word;
    cmd.pv     = claim;

    if (accept) begin
      unique case (in_data.req_type)
        REQ_INSERT, REQ_QUERY: begin
          busy_nxt        = 1'b1;
          req_nxt         = in_data.req_type;
          kok_nxt         = (|in_data.kth_index) && ((kadj >> size_r) == '0);
          launch_nxt.vld  = 1'b1;
          launch_nxt.word = in_data.value;
          launch_nxt.mx   = in_data.value;
          launch_nxt.mn   = in_data.value;
          launch_nxt.kk   = kadj << shamt;
        end
        REQ_CLEAR: begin
          zf_nxt   = 1'b0;
          size_nxt = '0;
          cmd.clr  = 1'b1;
          out_nxt  = '0;
          ov_nxt   = 1'b1;
        end
        default: begin
          out_nxt                = '0;
          out_nxt.basis_size     = size_r;
          out_nxt.zero_reachable = zf_r;
          ov_nxt                 = 1'b1;
        end
      endcase
    end

    // The token leaves the bottom row: finish the beat.
    if (tail.vld) begin
      busy_nxt = 1'b0;
      out_nxt  = '0;
      ov_nxt   = 1'b1;
      if (req_r == REQ_INSERT) begin
        cmd.commit = ins;
        size_nxt   = size_r + SW'(ins);
        zf_nxt     = zf_r | ~ins;
        out_nxt.inserted       = ins;
        out_nxt.basis_size     = size_nxt;
        out_nxt.zero_reachable = zf_nxt;
      end else begin
        out_nxt.representable  = ~ins;
        out_nxt.max_xor        = tail.mx;
        out_nxt.min_xor        = tail.mn;
        out_nxt.smallest_row   = tail.sm;
        out_nxt.smallest_valid = tail.smv;
        out_nxt.kth_value      = kok_r ? tail.acc : '0;
        out_nxt.kth_valid      = kok_r;
        out_nxt.rank_of_value  = tail.rank;
        out_nxt.basis_size     = size_r;
        out_nxt.zero_reachable = zf_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      req_r    <= REQ_INSERT;
      zf_r     <= 1'b0;
      size_r   <= '0;
      kok_r    <= 1'b0;
      ov_r     <= 1'b0;
      launch_r <= '0;
    end else begin
      busy_r   <= busy_nxt;
      req_r    <= req_nxt;
      zf_r     <= zf_nxt;
      size_r   <= size_nxt;
      kok_r    <= kok_nxt;
      ov_r     <= ov_nxt;
      launch_r <= launch_nxt;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

endmodule
`default_nettype wire

// ===== rtl/xlb_checker.sv =====
`default_nettype none
`include "xor_linear_basis_defines.svh"
module xlb_checker import xlb_pkg::*; (
  input wire      clk,
  input wire      rst_n,
  input wire      in_valid,
  input wire      in_stall,
  input xlb_in_t  in_data,
  input wire      out_valid,
  input wire      out_stall,
  input xlb_out_t out_data
);

  // A stalled result beat holds.
  `XLB_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // An insert or query beat keeps the input stalled while its token walks.
  `XLB_ASSERT_NEXT(a_busy_after_walk_start,
    in_valid && !in_stall && (in_data.req_type == REQ_INSERT ||
    in_data.req_type == REQ_QUERY), in_stall)

  // A clear beat answers at once with an empty basis.
  `XLB_ASSERT_NEXT(a_clear_result, in_valid && !in_stall && in_data.req_type == REQ_CLEAR,
    out_valid && out_data.basis_size == '0 && !out_data.zero_reachable)

  // The basis never holds more rows than pivot bits.
  `XLB_ASSERT_IMPL(a_size_bound, out_valid, out_data.basis_size <= SW'(W))

endmodule

bind xor_linear_basis xlb_checker u_xlb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire

// ===== verif/tb_xor_linear_basis.sv =====
`default_nettype none
module tb_xor_linear_basis;
  import xlb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Request code with no meaning to the block; it must leave the state alone.
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;
  localparam int NUM_RANDOM = 450;
  localparam int NUM_DIRECTED = 20;
  localparam int HOLD_OFF_CYCLES = 500;
  localparam int HOLD_OFF_AT = 120;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  xlb_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  xlb_out_t out_data;

  xor_linear_basis i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // Shadow copy of the basis and the zero-reachable flag.
  logic [W-1:0] shadow_rows [W];
  logic         shadow_zero;

  xlb_out_t pending_results [$];
  int       mismatches;
  int       results_seen;

  // Clock, period 2 ns.
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Hard stop in case the block hangs.
  initial begin
    #1000000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic int basis_count();
    int n;
    n = 0;
    for (int i = 0; i < W; i++) if (shadow_rows[i] != '0) n++;
    return n;
  endfunction

  // Updates the shadow basis for one beat and returns the result it must give.
  function automatic xlb_out_t basis_step(xlb_in_t beat);
    xlb_out_t     r;
    logic [W-1:0] v;
    logic [W-1:0] mx;
    logic [W-1:0] mn;
    logic [W-1:0] acc;
    logic [63:0]  kk;
    int           idx;
    int           size;
    bit           placed;
    r = '0;
    v = beat.value;
    kk = {2'b00, beat.kth_index};
    case (beat.req_type)
      REQ_INSERT: begin
        placed = 1'b0;
        for (int j = TOP_BIT; j >= 0 && !placed; j--) begin
          if (v[j]) begin
            if (shadow_rows[j] != '0) begin
              v ^= shadow_rows[j];
            end else begin
              // Fully reduce the new row, then clear its pivot from higher rows.
              for (int k = 0; k < j; k++) if (v[k]) v ^= shadow_rows[k];
              for (int k = j + 1; k < W; k++) if (shadow_rows[k][j]) shadow_rows[k] ^= v;
              shadow_rows[j] = v;
              placed = 1'b1;
            end
          end
        end
        if (!placed) shadow_zero = 1'b1;
        r.inserted = placed;
      end
      REQ_CLEAR: begin
        for (int i = 0; i < W; i++) shadow_rows[i] = '0;
        shadow_zero = 1'b0;
      end
      REQ_QUERY: begin
        size = basis_count();
        acc = v;
        for (int j = TOP_BIT; j >= 0; j--)
          if (acc[j] && shadow_rows[j] != '0) acc ^= shadow_rows[j];
        r.representable = (acc == '0);
        mx = v;
        mn = v;
        for (int i = TOP_BIT; i >= 0; i--) begin
          if ((mx ^ shadow_rows[i]) > mx) mx ^= shadow_rows[i];
          if ((mn ^ shadow_rows[i]) < mn) mn ^= shadow_rows[i];
        end
        r.max_xor = mx;
        r.min_xor = mn;
        for (int i = TOP_BIT; i >= 0; i--) begin
          if (shadow_rows[i] != '0) begin
            r.smallest_row = shadow_rows[i];
            r.smallest_valid = 1'b1;
          end
        end
        // Zero is the first value only when the flag is set.
        if (kk != 0) begin
          if (shadow_zero) kk = kk - 1;
          if (shadow_zero && kk == 0) begin
            r.kth_valid = 1'b1;
          end else if (kk < (64'd1 << size)) begin
            acc = '0;
            idx = 0;
            for (int i = 0; i < W; i++) begin
              if (shadow_rows[i] != '0) begin
                if (kk[idx]) acc ^= shadow_rows[i];
                idx++;
              end
            end
            r.kth_value = acc;
            r.kth_valid = 1'b1;
          end
        end
        acc = '0;
        idx = 0;
        for (int i = 0; i < W; i++) begin
          if (shadow_rows[i] != '0) begin
            if (v[i]) acc[idx] = 1'b1;
            idx++;
          end
        end
        r.rank_of_value = acc;
      end
      default: ;
    endcase
    r.basis_size = SW'(basis_count());
    r.zero_reachable = shadow_zero;
    return r;
  endfunction

  function automatic xlb_in_t make_beat(logic [1:0] req, logic [W-1:0] v, logic [KW-1:0] k);
    xlb_in_t b;
    b.req_type = req;
    b.value = v;
    b.kth_index = k;
    return b;
  endfunction

  function automatic logic [W-1:0] random_word();
    logic [W-1:0] w;
    int           kind;
    kind = $urandom_range(0, 9);
    w = W'({$urandom, $urandom});
    if (kind < 3) begin
      // Sparse words make dependent inserts likely.
      w = '0;
      w[$urandom_range(0, TOP_BIT)] = 1'b1;
      w[$urandom_range(0, TOP_BIT)] = 1'b1;
    end else if (kind < 6) begin
      // A combination of present rows, sometimes with one bit flipped.
      w = '0;
      for (int i = 0; i < W; i++) if ($urandom_range(0, 1)) w ^= shadow_rows[i];
      if (kind == 5) w[$urandom_range(0, TOP_BIT)] ^= 1'b1;
    end else if (kind == 6) begin
      w = W'($urandom_range(0, 15));
    end
    return w;
  endfunction

  function automatic logic [KW-1:0] random_rank();
    int kind;
    int size;
    kind = $urandom_range(0, 9);
    size = basis_count();
    if (kind < 4) return KW'($urandom_range(0, 20));
    if (kind < 7) return KW'({$urandom, $urandom}) & ((KW'(1) << (size + 1)) - 1);
    if (kind == 7) return '1;
    return KW'({$urandom, $urandom});
  endfunction

  function automatic bit result_matches(xlb_out_t exp_r, xlb_out_t got);
    return exp_r === got;
  endfunction

  // Offers one beat and waits for acceptance; the next beat may follow at once.
  task automatic send_beat(xlb_in_t beat, bit typed, xlb_out_t typed_result, int gap);
    xlb_out_t predicted;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= beat;
    do @(posedge clk); while (in_stall);
    predicted = basis_step(beat);
    pending_results = {pending_results, (typed ? typed_result : predicted)};
  endtask

  // Result side: random stalls, one long hold-off, and the check of each beat.
  initial begin
    xlb_out_t exp_r;
    int       wait_cycles;
    bit       held;
    out_stall = 1'b0;
    held = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (!held && results_seen == HOLD_OFF_AT) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
        if (wait_cycles > 0) begin
          out_stall <= 1'b1;
          repeat (wait_cycles) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result beat: %p", out_data);
      end else begin
        exp_r = pending_results.pop_front();
        if (!result_matches(exp_r, out_data)) begin
          mismatches++;
          if (mismatches <= 10) $display("Result mismatch:\n  expected %p\n  actual   %p",
                                         exp_r, out_data);
        end
      end
    end
  end

  // Reset, directed table, random beats, then drain.
  initial begin
    xlb_in_t  dir_beat [NUM_DIRECTED];
    xlb_out_t dir_result [NUM_DIRECTED];
    bit       dir_typed [NUM_DIRECTED];
    xlb_out_t r;
    xlb_in_t  beat;
    int       pick;
    int       gap;
    bit       burst;
    int       guard;
    mismatches = 0;
    results_seen = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    for (int i = 0; i < W; i++) shadow_rows[i] = '0;
    shadow_zero = 1'b0;
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      dir_typed[i] = 1'b0;
      dir_result[i] = '0;
    end

    // Empty basis: zero is representable, nothing else is known.
    dir_beat[0] = make_beat(REQ_QUERY, '0, KW'(1));
    dir_typed[0] = 1'b1;
    r = '0;
    r.representable = 1'b1;
    dir_result[0] = r;
    // Empty basis with the widest value and a zero rank.
    dir_beat[1] = make_beat(REQ_QUERY, '1, '0);
    dir_typed[1] = 1'b1;
    r = '0;
    r.max_xor = '1;
    r.min_xor = '1;
    dir_result[1] = r;
    // Unknown request carries only the status fields.
    dir_beat[2] = make_beat(REQ_UNKNOWN, '1, '1);
    dir_typed[2] = 1'b1;
    dir_result[2] = '0;
    dir_beat[3] = make_beat(REQ_INSERT, '1, '1);
    dir_beat[4] = make_beat(REQ_INSERT, W'(1), '0);
    dir_beat[5] = make_beat(REQ_INSERT, W'(1), '0);
    dir_beat[6] = make_beat(REQ_INSERT, '0, '0);
    dir_beat[7] = make_beat(REQ_INSERT, W'(1) << TOP_BIT, '0);
    dir_beat[8] = make_beat(REQ_INSERT, {(W+1)/2{2'b01}}, '0);
    dir_beat[9] = make_beat(REQ_QUERY, '1, KW'(1));
    dir_beat[10] = make_beat(REQ_QUERY, W'(5), KW'(2));
    dir_beat[11] = make_beat(REQ_QUERY, W'(1) << TOP_BIT, '1);
    dir_beat[12] = make_beat(REQ_QUERY, '0, '0);
    dir_beat[13] = make_beat(REQ_UNKNOWN, W'(7), KW'(3));
    // Clear empties everything.
    dir_beat[14] = make_beat(REQ_CLEAR, '1, '1);
    dir_typed[14] = 1'b1;
    dir_result[14] = '0;
    // After clear the query sees an empty basis again.
    dir_beat[15] = make_beat(REQ_QUERY, W'(123), KW'(1));
    dir_typed[15] = 1'b1;
    r = '0;
    r.max_xor = W'(123);
    r.min_xor = W'(123);
    dir_result[15] = r;
    dir_beat[16] = make_beat(REQ_INSERT, W'(2), '0);
    dir_beat[17] = make_beat(REQ_INSERT, W'(3), '0);
    dir_beat[18] = make_beat(REQ_QUERY, W'(1), KW'(4));
    dir_beat[19] = make_beat(REQ_QUERY, W'(3), KW'(3));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NUM_DIRECTED; i++)
      send_beat(dir_beat[i], dir_typed[i], dir_result[i], $urandom_range(0, 10));

    // Random beats, in stretches of 40 that are gapped or back-to-back at random.
    burst = 1'b0;
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n % 40 == 0) burst = $urandom_range(0, 1);
      pick = $urandom_range(0, 99);
      if (pick < 48) beat = make_beat(REQ_INSERT, random_word(), random_rank());
      else if (pick < 94) beat = make_beat(REQ_QUERY, random_word(), random_rank());
      else if (pick < 97) beat = make_beat(REQ_CLEAR, random_word(), random_rank());
      else beat = make_beat(REQ_UNKNOWN, random_word(), random_rank());
      gap = burst ? 0 : $urandom_range(0, 10);
      send_beat(beat, 1'b0, '0, gap);
    end
    in_valid <= 1'b0;

    guard = 0;
    while (pending_results.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (100) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
